FILE: sv/ihex_pkg.sv
`default_nettype none
package ihex_pkg;

  // One input word: a data byte and its record framing.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [7:0]  record_length;
    logic [15:0] load_address;
    logic        first_of_record;
    logic        last_of_record;
  } in_word_t;

  // One output word: a character of the record line.
  typedef struct packed {
    logic [6:0] ascii_char;
    logic       end_of_line;
  } out_word_t;

  // Classified entry handed from the front to the back.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [7:0]  record_length;
    logic [15:0] load_address;
    logic        first_of_record;
    logic        last_of_record;
    logic [7:0]  checksum;
  } ihex_entry_t;

  // Character positions of a record line.
  typedef enum logic [3:0] {
    PH_COLON,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_ADDR_3,
    PH_ADDR_2,
    PH_ADDR_1,
    PH_ADDR_0,
    PH_TYPE_HI,
    PH_TYPE_LO,
    PH_DATA_HI,
    PH_DATA_LO,
    PH_CHK_HI,
    PH_CHK_LO,
    PH_CR,
    PH_LF
  } ihex_phase_t;

  localparam logic [6:0] CHAR_COLON = 7'h3A;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_CR    = 7'h0D;
  localparam logic [6:0] CHAR_LF    = 7'h0A;
  localparam logic [6:0] CHAR_ALPHA = 7'h37;  // 'A' minus ten

  // Upper-case hex digit of a nibble.
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] wide;
    wide = {3'b000, nib};
    if (nib < 4'd10) begin
      hex_char = CHAR_ZERO + wide;
    end else begin
      hex_char = CHAR_ALPHA + wide;
    end
  endfunction

endpackage
`default_nettype wire

FILE: sv/ihex_front.sv
`default_nettype none
module ihex_front
  import ihex_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire in_word_t    in_word,
  input  wire logic        q_full,
  output logic             q_push,
  output ihex_entry_t      q_entry
);

  logic [7:0] running_sum_r;
  logic [7:0] running_sum_nxt;
  logic [7:0] base_sum;
  logic [7:0] byte_sum;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  // Restart the sum from the header bytes on a first word.
  always_comb begin
    if (in_word.first_of_record) begin
      base_sum = in_word.record_length + in_word.load_address[15:8]
               + in_word.load_address[7:0];
    end else begin
      base_sum = running_sum_r;
    end
    byte_sum = base_sum + in_word.data_byte;
    running_sum_nxt = in_word.last_of_record ? 8'h00 : byte_sum;
  end

  always_comb begin
    q_entry.data_byte       = in_word.data_byte;
    q_entry.record_length   = in_word.record_length;
    q_entry.load_address    = in_word.load_address;
    q_entry.first_of_record = in_word.first_of_record;
    q_entry.last_of_record  = in_word.last_of_record;
    q_entry.checksum        = 8'h00 - byte_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_sum_r <= 8'h00;
    end else if (q_push) begin
      running_sum_r <= running_sum_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/ihex_queue.sv
`default_nettype none
module ihex_queue
  import ihex_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire ihex_entry_t push_entry,
  output logic             full,
  input  wire logic        pop,
  output ihex_entry_t      head_entry,
  output logic             nonempty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ihex_entry_t slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign nonempty   = (count_r != '0);
  assign do_push    = push && !full;
  assign do_pop     = pop && nonempty;
  assign head_entry = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/ihex_back.sv
`default_nettype none
module ihex_back
  import ihex_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_nonempty,
  input  wire ihex_entry_t q_head,
  output logic             q_pop,
  output logic             out_empty,
  input  wire logic        out_pop,
  output out_word_t        out_word
);

  ihex_entry_t cur_r;
  logic        busy_r;
  logic        busy_nxt;
  ihex_phase_t phase_r;
  ihex_phase_t phase_nxt;
  ihex_phase_t advance;
  logic        at_end;
  logic        take;
  logic        load;

  assign take   = busy_r && out_pop;
  assign at_end = (phase_r == PH_LF)
               || (phase_r == PH_DATA_LO && !cur_r.last_of_record);
  assign load   = q_nonempty && (!busy_r || (take && at_end));
  assign q_pop  = load;
  assign out_empty = !busy_r;

  // Next state: step through the line, reload from the queue at the end.
  always_comb begin
    unique case (phase_r)
      PH_COLON:   advance = PH_LEN_HI;
      PH_LEN_HI:  advance = PH_LEN_LO;
      PH_LEN_LO:  advance = PH_ADDR_3;
      PH_ADDR_3:  advance = PH_ADDR_2;
      PH_ADDR_2:  advance = PH_ADDR_1;
      PH_ADDR_1:  advance = PH_ADDR_0;
      PH_ADDR_0:  advance = PH_TYPE_HI;
      PH_TYPE_HI: advance = PH_TYPE_LO;
      PH_TYPE_LO: advance = PH_DATA_HI;
      PH_DATA_HI: advance = PH_DATA_LO;
      PH_DATA_LO: advance = PH_CHK_HI;
      PH_CHK_HI:  advance = PH_CHK_LO;
      PH_CHK_LO:  advance = PH_CR;
      PH_CR:      advance = PH_LF;
      PH_LF:      advance = PH_COLON;
      default:    advance = PH_COLON;
    endcase
    phase_nxt = phase_r;
    busy_nxt  = busy_r;
    if (load) begin
      busy_nxt  = 1'b1;
      phase_nxt = q_head.first_of_record ? PH_COLON : PH_DATA_HI;
    end else if (take) begin
      if (at_end) begin
        busy_nxt = 1'b0;
      end else begin
        phase_nxt = advance;
      end
    end
  end

  // Outputs: character of the current position.
  always_comb begin
    out_word.end_of_line = 1'b0;
    unique case (phase_r)
      PH_COLON:   out_word.ascii_char = CHAR_COLON;
      PH_LEN_HI:  out_word.ascii_char = hex_char(cur_r.record_length[7:4]);
      PH_LEN_LO:  out_word.ascii_char = hex_char(cur_r.record_length[3:0]);
      PH_ADDR_3:  out_word.ascii_char = hex_char(cur_r.load_address[15:12]);
      PH_ADDR_2:  out_word.ascii_char = hex_char(cur_r.load_address[11:8]);
      PH_ADDR_1:  out_word.ascii_char = hex_char(cur_r.load_address[7:4]);
      PH_ADDR_0:  out_word.ascii_char = hex_char(cur_r.load_address[3:0]);
      PH_TYPE_HI: out_word.ascii_char = CHAR_ZERO;
      PH_TYPE_LO: out_word.ascii_char = CHAR_ZERO;
      PH_DATA_HI: out_word.ascii_char = hex_char(cur_r.data_byte[7:4]);
      PH_DATA_LO: out_word.ascii_char = hex_char(cur_r.data_byte[3:0]);
      PH_CHK_HI:  out_word.ascii_char = hex_char(cur_r.checksum[7:4]);
      PH_CHK_LO:  out_word.ascii_char = hex_char(cur_r.checksum[3:0]);
      PH_CR:      out_word.ascii_char = CHAR_CR;
      PH_LF: begin
        out_word.ascii_char  = CHAR_LF;
        out_word.end_of_line = 1'b1;
      end
      default:    out_word.ascii_char = CHAR_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= PH_COLON;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/intel_hex_record_encoder.sv
// Intel HEX data record encoder.
//
// Input channel (in_push / in_full / in_word): one word per data byte, with
// first_of_record and last_of_record marking the record frame. Length and
// load address are taken only from a first word.
// Output channel (out_empty / out_pop / out_word): one ASCII character per
// word; end_of_line is set on the final LF of each record.
//
// A plain byte gives 2 characters, a first byte 9 more for the header and a
// last byte 4 more for checksum and CR LF. The output side moves one
// character a cycle while the receiver keeps popping and, between entries,
// the queue is not empty; the character sequencer in the back end sets this.
// With the back end idle, an accepted word is written to the queue and then
// loaded into the back end's entry register; then its first character shows.
// The front keeps the running checksum and accepts at once; QUEUE_DEPTH
// entries buffer words between front and back.
// Reset clears the checksum, the queue and the sequencer; nothing is shown.
// When the receiver stalls, the current character holds and the queue fills;
// in_full rises once it is full.
`default_nettype none
module intel_hex_record_encoder
  import ihex_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_push,
  output logic           in_full,
  input  wire in_word_t  in_word,
  output logic           out_empty,
  input  wire logic      out_pop,
  output out_word_t      out_word
);

  logic        q_full;
  logic        q_push;
  ihex_entry_t q_entry;
  logic        q_pop;
  ihex_entry_t q_head;
  logic        q_nonempty;

  // Front: accept words, advance the checksum, classify.
  ihex_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_word (in_word),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  // Queue: decouple acceptance from character output.
  ihex_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_entry (q_head),
    .nonempty   (q_nonempty)
  );

  // Back: walk each entry through its characters, one per pop.
  ihex_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_word   (out_word)
  );

endmodule
`default_nettype wire
